/* rtl/aabb_pkg.sv */
package aabb_pkg;

	localparam int CAPACITY   = 64;
	localparam int ID_BITS    = 16;
	localparam int COORD_BITS = 32;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int CNT_BITS   = 7;
	localparam int ENTRY_BITS = ID_BITS + 6 * COORD_BITS;
	localparam int IN_BITS    = 3 + ID_BITS + 6 * COORD_BITS;
	localparam int IN_BYTES   = (IN_BITS + 7) / 8;
	localparam int OUT_BITS   = 3 + ID_BITS + CNT_BITS;
	localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

	localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

	typedef logic [2:0] op_t;
	localparam op_t OP_ADD    = 3'd0;
	localparam op_t OP_UPDATE = 3'd1;
	localparam op_t OP_REMOVE = 3'd2;
	localparam op_t OP_QUERY  = 3'd3;
	localparam op_t OP_CLEAR  = 3'd4;

	typedef logic [2:0] status_t;
	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_REPLACED = 3'd1;
	localparam status_t ST_REMOVED  = 3'd2;
	localparam status_t ST_ABSENT   = 3'd3;
	localparam status_t ST_FULL     = 3'd4;
	localparam status_t ST_HIT      = 3'd5;
	localparam status_t ST_NONE     = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_SHIFT,
		S_QUERY,
		S_OUT
	} state_t;

endpackage

/* rtl/aabb_table_overlap_query.sv */
// Clear and unused ops go straight to the result in the output register; a query scans
// every stored entry, and its hits come out during the scan; add, update and remove run
// a linear id search, then one entry move per cycle.
// Throughput: one item at a time; ready again as soon as the final result is loaded.
// Output stalls freeze a query scan and hold back the final result of any item.
// Reset (arst_n low, asynchronous) empties the table and drops any waiting result.
module aabb_table_overlap_query (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: op, obj_id, box_min_x, box_min_y, box_min_z, box_max_x,
	// box_max_y, box_max_z, zero fill
	input  logic [aabb_pkg::IN_BYTES*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: status, hit_id, stored_count, zero fill
	output logic [aabb_pkg::OUT_BYTES*8-1:0] m_tdata,
	output logic m_tlast
);
	import aabb_pkg::*;

	localparam int CB = COORD_BITS;

	// One table memory, one entry per word: id then six bounds. The entries
	// below count_q are kept sorted by ascending id.
	logic [ENTRY_BITS-1:0] mem [CAPACITY];
	logic [ENTRY_BITS-1:0] rd_q;

	state_t                state_q, state_d;
	logic [IN_BITS-1:0]    item_q;
	logic [CNT_BITS-1:0]   count_q, count_d;
	logic [CNT_BITS-1:0]   ptr_q, ptr_d;      // next entry to read
	logic [CNT_BITS-1:0]   left_q, left_d;    // entry moves not yet read
	logic [CNT_BITS-1:0]   rda_q, rda_d;      // index of the entry held in rd_q
	logic                  rd_ok_q, rd_ok_d;  // rd_q holds an entry to look at
	logic [CNT_BITS-1:0]   pos_q, pos_d;      // slot of the id, or where it goes
	logic                  eq_q, eq_d;        // the id is stored at pos_q
	logic                  pend_v_q, pend_v_d;
	logic [ID_BITS-1:0]    pend_id_q, pend_id_d;
	logic [OUT_BITS-1:0]   out_q;
	logic                  out_last_q;

	// Fields of the captured item.
	op_t                  op;
	logic [ID_BITS-1:0]   id;
	logic signed [CB-1:0] qmnx, qmny, qmnz, qmxx, qmxy, qmxz;
	assign op   = item_q[2:0];
	assign id   = item_q[3 +: ID_BITS];
	assign qmnx = item_q[3+ID_BITS+0*CB +: CB];
	assign qmny = item_q[3+ID_BITS+1*CB +: CB];
	assign qmnz = item_q[3+ID_BITS+2*CB +: CB];
	assign qmxx = item_q[3+ID_BITS+3*CB +: CB];
	assign qmxy = item_q[3+ID_BITS+4*CB +: CB];
	assign qmxz = item_q[3+ID_BITS+5*CB +: CB];

	// Fields of the entry read last cycle.
	logic [ID_BITS-1:0] e_id;
	logic signed [CB-1:0] emnx, emny, emnz, emxx, emxy, emxz;
	assign e_id = rd_q[0 +: ID_BITS];
	assign emnx = rd_q[ID_BITS+0*CB +: CB];
	assign emny = rd_q[ID_BITS+1*CB +: CB];
	assign emnz = rd_q[ID_BITS+2*CB +: CB];
	assign emxx = rd_q[ID_BITS+3*CB +: CB];
	assign emxy = rd_q[ID_BITS+4*CB +: CB];
	assign emxz = rd_q[ID_BITS+5*CB +: CB];

	// Inclusive overlap on all three axes, signed compares. An inverted box
	// is used exactly as stored.
	logic hit;
	assign hit = emnx <= qmxx && emxx >= qmnx
		&& emny <= qmxy && emxy >= qmny
		&& emnz <= qmxz && emxz >= qmnz;

	// A table entry built from the item: id in the low bits, then the bounds.
	logic [ENTRY_BITS-1:0] new_entry;
	assign new_entry = item_q[3 +: ENTRY_BITS];

	op_t in_op;
	assign in_op = s_tdata[2:0];

	// The output register may still hold the last result while the next item
	// is taken; a busy output only freezes work that has a result to give.
	assign s_tready = (state_q == S_IDLE);
	assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, out_q};
	assign m_tlast  = out_last_q;

	logic out_busy;
	assign out_busy = m_tvalid && !m_tready;

	// Memory port controls: one read and one write per cycle.
	logic                  mem_we, mem_re;
	logic [IDX_BITS-1:0]   mem_wa, mem_ra;
	logic [ENTRY_BITS-1:0] mem_wd;

	logic                emit, emit_last;
	status_t             emit_st;
	logic [ID_BITS-1:0]  emit_id;
	logic [CNT_BITS-1:0] emit_cnt;
	logic                f_eq;
	logic [CNT_BITS-1:0] f_pos;
	logic [CNT_BITS-1:0] mv_dst;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		left_d    = left_q;
		rda_d     = rda_q;
		rd_ok_d   = rd_ok_q;
		pos_d     = pos_q;
		eq_d      = eq_q;
		pend_v_d  = pend_v_q;
		pend_id_d = pend_id_q;
		mem_re    = 1'b0;
		mem_ra    = ptr_q[IDX_BITS-1:0];
		mem_we    = 1'b0;
		mem_wa    = pos_q[IDX_BITS-1:0];
		mem_wd    = new_entry;
		emit      = 1'b0;
		emit_last = 1'b1;
		emit_st   = ST_ABSENT;
		emit_id   = '0;
		emit_cnt  = count_q;
		f_eq      = 1'b0;
		f_pos     = count_q;
		// An add moves entries one slot up, a remove one slot down.
		mv_dst    = (op == OP_ADD) ? rda_q + 1'b1 : rda_q - 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ptr_d    = '0;
					rd_ok_d  = 1'b0;
					eq_d     = 1'b0;
					pend_v_d = 1'b0;
					unique case (in_op) inside
						OP_ADD, OP_UPDATE, OP_REMOVE: state_d = S_FIND;
						OP_QUERY: state_d = S_QUERY;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_FIND: begin
				// Linear search for the first stored id that is not below the
				// key; reads run one ahead of the compare.
				rd_ok_d = 1'b0;
				if ((rd_ok_q && e_id >= id) || ptr_q >= count_q) begin
					if (rd_ok_q && e_id >= id) begin
						f_pos = rda_q;
						f_eq  = (e_id == id);
					end
					pos_d   = f_pos;
					eq_d    = f_eq;
					state_d = S_SHIFT;
					left_d  = '0;
					if (op == OP_ADD && !f_eq && count_q < CAP_CNT) begin
						// Open a gap: move entries pos..count-1 up, top first.
						left_d = count_q - f_pos;
						ptr_d  = count_q - 1'b1;
					end else if (op == OP_REMOVE && f_eq) begin
						// Close the gap: move entries pos+1..count-1 down.
						left_d = count_q - f_pos - 1'b1;
						ptr_d  = f_pos + 1'b1;
					end
				end else begin
					mem_re  = 1'b1;
					rda_d   = ptr_q;
					rd_ok_d = 1'b1;
					ptr_d   = ptr_q + 1'b1;
				end
			end
			S_SHIFT: begin
				// Each cycle writes the entry read last cycle to its new slot
				// and reads the next one.
				if (rd_ok_q) begin
					mem_we = 1'b1;
					mem_wa = mv_dst[IDX_BITS-1:0];
					mem_wd = rd_q;
				end
				if (left_q != '0) begin
					mem_re  = 1'b1;
					rda_d   = ptr_q;
					rd_ok_d = 1'b1;
					left_d  = left_q - 1'b1;
					ptr_d   = (op == OP_ADD) ? ptr_q - 1'b1 : ptr_q + 1'b1;
				end else begin
					rd_ok_d = 1'b0;
					if (!rd_ok_q) begin
						state_d = S_OUT;
						// The new box goes in on a replace or an insert.
						if ((eq_q && (op == OP_ADD || op == OP_UPDATE))
							|| (op == OP_ADD && !eq_q && count_q < CAP_CNT)) begin
							mem_we = 1'b1;
							mem_wa = pos_q[IDX_BITS-1:0];
							mem_wd = new_entry;
						end
					end
				end
			end
			S_QUERY: begin
				// Scan every stored entry. The newest hit is held back one step
				// so that the final one can carry the last flag.
				if (!out_busy) begin
					if (rd_ok_q && hit) begin
						if (pend_v_q) begin
							emit      = 1'b1;
							emit_last = 1'b0;
							emit_st   = ST_HIT;
							emit_id   = pend_id_q;
						end
						pend_v_d  = 1'b1;
						pend_id_d = e_id;
					end
					if (ptr_q < count_q) begin
						mem_re  = 1'b1;
						rda_d   = ptr_q;
						rd_ok_d = 1'b1;
						ptr_d   = ptr_q + 1'b1;
					end else begin
						rd_ok_d = 1'b0;
						state_d = S_OUT;
					end
				end
			end
			S_OUT: begin
				// The final result of the item.
				if (!out_busy) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					unique case (op) inside
						OP_QUERY: begin
							if (pend_v_q) begin
								emit_st = ST_HIT;
								emit_id = pend_id_q;
							end else begin
								emit_st = ST_NONE;
							end
						end
						OP_CLEAR: begin
							emit_st = ST_NONE;
							count_d = '0;
						end
						OP_ADD: begin
							if (eq_q) begin
								emit_st = ST_REPLACED;
							end else if (count_q >= CAP_CNT) begin
								emit_st = ST_FULL;
							end else begin
								emit_st = ST_INSERTED;
								count_d = count_q + 1'b1;
							end
						end
						OP_UPDATE: emit_st = eq_q ? ST_REPLACED : ST_ABSENT;
						OP_REMOVE: begin
							if (eq_q) begin
								emit_st = ST_REMOVED;
								count_d = count_q - 1'b1;
							end
						end
						default: emit_st = ST_ABSENT;
					endcase
					emit_cnt = count_d;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			left_q     <= '0;
			rda_q      <= '0;
			rd_ok_q    <= 1'b0;
			pos_q      <= '0;
			eq_q       <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_id_q  <= '0;
			m_tvalid   <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ptr_q     <= ptr_d;
			left_q    <= left_d;
			rda_q     <= rda_d;
			rd_ok_q   <= rd_ok_d;
			pos_q     <= pos_d;
			eq_q      <= eq_d;
			pend_v_q  <= pend_v_d;
			pend_id_q <= pend_id_d;
			if (emit) begin
				m_tvalid   <= 1'b1;
				out_q      <= {emit_cnt, emit_id, emit_st};
				out_last_q <= emit_last;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Table memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= s_tdata[IN_BITS-1:0];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("table count above capacity");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !s_tready)
		else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("result changed while waiting");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_busy && op == OP_CLEAR) |=> count_q == '0)
		else $error("clear did not empty table");

endmodule
